@@ rtl/core/mafhd_pkg.sv @@
// ----------------------------------------------------------------------------
// mafhd_pkg: MPEG audio frame header decode package
// Shared types, codes, rate tables and reciprocal constants for the header
// decode pipeline.
// ----------------------------------------------------------------------------
package mafhd_pkg;

    // Port widths
    localparam int HDR_W   = 32;
    localparam int SYNC_W  = 2;
    localparam int ODATA_W = 56;

    // Field widths
    localparam int KBPS_W  = 9;
    localparam int FACT_W  = 12;
    localparam int NUM_W   = KBPS_W + FACT_W;
    localparam int RATE_W  = 10;
    localparam int RECIP_W = 24;
    localparam int RECIP_S = 32;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int QUOT_W  = 12;
    localparam int QR_W    = QUOT_W + RATE_W;
    localparam int FB_W    = 12;
    localparam int BPS_W   = 19;

    // Sync kinds
    localparam logic [SYNC_W-1:0] SYNC_NONE   = 2'd0;
    localparam logic [SYNC_W-1:0] SYNC_MPEG12 = 2'd1;
    localparam logic [SYNC_W-1:0] SYNC_MPEG25 = 2'd2;

    // Layer codes
    localparam logic [1:0] LAYER_RSVD = 2'd0;
    localparam logic [1:0] LAYER_III  = 2'd1;
    localparam logic [1:0] LAYER_II   = 2'd2;
    localparam logic [1:0] LAYER_I    = 2'd3;

    // Sample-rate index reserved code
    localparam logic [1:0] SRI_RSVD = 2'd3;

    // Length factors
    localparam logic [FACT_W-1:0] FACT_240  = 12'd240;
    localparam logic [FACT_W-1:0] FACT_1440 = 12'd1440;
    localparam logic [FACT_W-1:0] FACT_2880 = 12'd2880;

    localparam logic [9:0] BPS_SCALE = 10'd1000;

    // Reciprocals floor(2^32 / r) for each sample rate / 50
    localparam logic [63:0] RECIP_441 = (64'd1 << RECIP_S) / 441;
    localparam logic [63:0] RECIP_480 = (64'd1 << RECIP_S) / 480;
    localparam logic [63:0] RECIP_320 = (64'd1 << RECIP_S) / 320;
    localparam logic [63:0] RECIP_882 = (64'd1 << RECIP_S) / 882;
    localparam logic [63:0] RECIP_960 = (64'd1 << RECIP_S) / 960;
    localparam logic [63:0] RECIP_640 = (64'd1 << RECIP_S) / 640;

    typedef logic [KBPS_W-1:0] kbps_t;

    // Bitrate tables in kbps, [version][index]
    localparam kbps_t KBPS_L1_V0 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
        9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
    localparam kbps_t KBPS_L1_V1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
        9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
    localparam kbps_t KBPS_L2_V0 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
        9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
    localparam kbps_t KBPS_L2_V1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
        9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
    localparam kbps_t KBPS_L3_V0 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
        9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};
    localparam kbps_t KBPS_L3_V1 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
        9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};

    // Unpacked header fields, carried down the pipe
    typedef struct packed {
        logic [SYNC_W-1:0] sync_kind;
        logic              version_id;
        logic [1:0]        layer_code;
        logic              protect_bit;
        logic [3:0]        bitrate_index;
        logic [1:0]        samplerate_index;
        logic              padding;
        logic [1:0]        channel_mode;
        logic [1:0]        mode_extension;
        logic [4:0]        aux_bits;
    } hdr_fields_t;

    // Bitrate lookup; layer reserved gives 0
    function automatic kbps_t kbps_lookup(input logic [1:0] layer, input logic ver,
                                          input logic [3:0] bri);
        kbps_t k;
        k = '0;
        unique case (layer)
            LAYER_I:   k = ver ? KBPS_L1_V1[bri] : KBPS_L1_V0[bri];
            LAYER_II:  k = ver ? KBPS_L2_V1[bri] : KBPS_L2_V0[bri];
            LAYER_III: k = ver ? KBPS_L3_V1[bri] : KBPS_L3_V0[bri];
            default:   k = '0;
        endcase
        return k;
    endfunction

    // Sample rate / 50; reserved index gives a nonzero dummy (numerator is zero)
    function automatic logic [RATE_W-1:0] rate_lookup(input logic ver,
                                                      input logic [1:0] sri);
        logic [RATE_W-1:0] r;
        r = 10'd1;
        unique case ({ver, sri})
            3'b000:  r = 10'd441;
            3'b001:  r = 10'd480;
            3'b010:  r = 10'd320;
            3'b100:  r = 10'd882;
            3'b101:  r = 10'd960;
            3'b110:  r = 10'd640;
            default: r = 10'd1;
        endcase
        return r;
    endfunction

    function automatic logic [RECIP_W-1:0] recip_lookup(input logic ver,
                                                        input logic [1:0] sri);
        logic [RECIP_W-1:0] m;
        m = '0;
        unique case ({ver, sri})
            3'b000:  m = RECIP_441[RECIP_W-1:0];
            3'b001:  m = RECIP_480[RECIP_W-1:0];
            3'b010:  m = RECIP_320[RECIP_W-1:0];
            3'b100:  m = RECIP_882[RECIP_W-1:0];
            3'b101:  m = RECIP_960[RECIP_W-1:0];
            3'b110:  m = RECIP_640[RECIP_W-1:0];
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

@@ rtl/core/mpeg_audio_frame_header_decode_unit.sv @@
// ----------------------------------------------------------------------------
// mpeg_audio_frame_header_decode_unit: MPEG audio frame header decoder
// Five-stage pipeline: unpack and table lookup, numerator and bitrate
// multiply, reciprocal multiply, back-multiply, remainder correction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one 32-bit header word per beat, first header byte in
//   bits 31..24. Master stream: one decoded beat per input beat, sync kind
//   in tuser, unpacked fields, frame length and bitrate in tdata.
//   A beat reaches output valid through stages 1 to 5. Throughput is one
//   header per cycle while tready is high; each stage holds a valid bit and
//   loads whenever it is empty or the next stage is taking its beat, so
//   bubbles are squeezed out. The frame length is floor(factor * kbps / r),
//   times four for layer I, computed as a multiply by a constant reciprocal
//   of r followed by one compare-and-subtract correction; this chain of two
//   multipliers sets the stage count. Reset clears all valid bits; the pipe
//   comes up empty and ready. When the receiver holds tready low, the output
//   beat stays put and the stages behind it keep filling until all five hold
//   a beat, then the slave side drops tready. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_header_decode_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [31:0] header_word
    input  logic [mafhd_pkg::HDR_W-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] version_id, [2:1] layer_code, [3] protect_bit, [7:4] bitrate_index,
    // [9:8] samplerate_index, [10] padding, [12:11] channel_mode,
    // [14:13] mode_extension, [19:15] aux_bits, [31:20] frame_bytes,
    // [50:32] bitrate_bps, [55:51] zero
    output logic [mafhd_pkg::ODATA_W-1:0] m_axis_tdata,
    // [1:0] sync_kind
    output logic [mafhd_pkg::SYNC_W-1:0]  m_axis_tuser
);
    import mafhd_pkg::*;

    // Stage enables
    logic en1, en2, en3, en4, en5;

    // Valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // Stage 1 registers
    hdr_fields_t        f1_reg, f1_next;
    kbps_t              kbps1_reg, kbps1_next;
    logic [FACT_W-1:0]  fact1_reg, fact1_next;
    logic [RATE_W-1:0]  r1_reg;
    logic [RECIP_W-1:0] m1_reg;

    // Stage 2 registers
    hdr_fields_t        f2_reg;
    logic [NUM_W-1:0]   num2_reg;
    logic [BPS_W-1:0]   bps2_reg;
    logic [RATE_W-1:0]  r2_reg;
    logic [RECIP_W-1:0] m2_reg;

    // Stage 3 registers
    hdr_fields_t        f3_reg;
    logic [NUM_W-1:0]   num3_reg;
    logic [BPS_W-1:0]   bps3_reg;
    logic [RATE_W-1:0]  r3_reg;
    logic [PROD_W-1:0]  prod3_reg;

    // Stage 4 registers
    hdr_fields_t        f4_reg;
    logic [NUM_W-1:0]   num4_reg;
    logic [BPS_W-1:0]   bps4_reg;
    logic [RATE_W-1:0]  r4_reg;
    logic [QUOT_W-1:0]  q4_reg;
    logic [QR_W-1:0]    qr4_reg;

    // Stage 5 (output) registers
    hdr_fields_t        f5_reg;
    logic [FB_W-1:0]    fb5_reg, fb5_next;
    logic [BPS_W-1:0]   bps5_reg, bps5_next;

    logic [QUOT_W-1:0]  q3_est;
    logic [QR_W-1:0]    rem4;
    logic [QUOT_W-1:0]  q4_fix;

    // Backpressure: a stage loads when empty or when its beat moves on
    assign en5 = !v5_reg || m_axis_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_axis_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: sync check, unpack, table lookups
    always_comb
    begin
        logic [HDR_W-1:0] h;
        logic             ok;
        h          = s_axis_tdata;
        f1_next    = '0;
        kbps1_next = '0;
        fact1_next = FACT_2880;
        if (h[31:24] == 8'hFF && h[23:20] == 4'hF)
            f1_next.sync_kind = SYNC_MPEG12;
        else if (h[31:24] == 8'hFF && h[23:20] == 4'hE)
            f1_next.sync_kind = SYNC_MPEG25;
        else
            f1_next.sync_kind = SYNC_NONE;

        if (f1_next.sync_kind != SYNC_NONE)
        begin
            f1_next.version_id       = h[19];
            f1_next.layer_code       = h[18:17];
            f1_next.protect_bit      = h[16];
            f1_next.bitrate_index    = h[15:12];
            f1_next.samplerate_index = h[11:10];
            f1_next.padding          = h[9];
            f1_next.channel_mode     = h[7:6];
            f1_next.mode_extension   = h[5:4];
            f1_next.aux_bits         = {h[8], h[3:0]};
        end

        // zero kbps forces frame length and bitrate to zero downstream
        ok = (f1_next.sync_kind != SYNC_NONE) && (f1_next.samplerate_index != SRI_RSVD);
        if (ok)
            kbps1_next = kbps_lookup(f1_next.layer_code, f1_next.version_id,
                                     f1_next.bitrate_index);

        priority if (f1_next.layer_code == LAYER_I)
            fact1_next = FACT_240;
        else if (f1_next.layer_code == LAYER_III && !f1_next.version_id
                 && f1_next.sync_kind != SYNC_MPEG25)
            fact1_next = FACT_1440;
        else
            fact1_next = FACT_2880;
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            f1_reg    <= f1_next;
            kbps1_reg <= kbps1_next;
            fact1_reg <= fact1_next;
            r1_reg    <= rate_lookup(f1_next.version_id, f1_next.samplerate_index);
            m1_reg    <= recip_lookup(f1_next.version_id, f1_next.samplerate_index);
        end
    end

    // Stage 2: numerator and bitrate products
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            f2_reg   <= f1_reg;
            num2_reg <= NUM_W'(kbps1_reg) * NUM_W'(fact1_reg);
            bps2_reg <= BPS_W'(kbps1_reg) * BPS_W'(BPS_SCALE);
            r2_reg   <= r1_reg;
            m2_reg   <= m1_reg;
        end
    end

    // Stage 3: quotient estimate by reciprocal multiply
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            f3_reg    <= f2_reg;
            num3_reg  <= num2_reg;
            bps3_reg  <= bps2_reg;
            r3_reg    <= r2_reg;
            prod3_reg <= PROD_W'(num2_reg) * PROD_W'(m2_reg);
        end
    end

    // estimate is the true quotient or one below
    assign q3_est = prod3_reg[RECIP_S +: QUOT_W];

    // Stage 4: back-multiply the estimate
    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            f4_reg   <= f3_reg;
            num4_reg <= num3_reg;
            bps4_reg <= bps3_reg;
            r4_reg   <= r3_reg;
            q4_reg   <= q3_est;
            qr4_reg  <= QR_W'(q3_est) * QR_W'(r3_reg);
        end
    end

    // Stage 5: remainder correction, layer I scaling, failure zeroing
    always_comb
    begin
        rem4   = QR_W'(num4_reg) - qr4_reg;
        q4_fix = (rem4 >= QR_W'(r4_reg)) ? q4_reg + QUOT_W'(1) : q4_reg;
        if (f4_reg.layer_code == LAYER_I)
            fb5_next = {q4_fix[FB_W-3:0], 2'b00};
        else
            fb5_next = q4_fix[FB_W-1:0];
        bps5_next = (fb5_next != '0) ? bps4_reg : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            f5_reg   <= f4_reg;
            fb5_reg  <= fb5_next;
            bps5_reg <= bps5_next;
        end
    end

    // Output beat
    assign m_axis_tvalid = v5_reg;
    assign m_axis_tuser  = f5_reg.sync_kind;
    assign m_axis_tdata  = {5'b00000, bps5_reg, fb5_reg, f5_reg.aux_bits,
                            f5_reg.mode_extension, f5_reg.channel_mode, f5_reg.padding,
                            f5_reg.samplerate_index, f5_reg.bitrate_index,
                            f5_reg.protect_bit, f5_reg.layer_code, f5_reg.version_id};

endmodule
